[design/sklbs_pkg.sv]
// sklbs_pkg: shared types and constants for the sorted key lower bound search
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sklbs_pkg;
  localparam int KEY_STORE_BYTES = 4096;
  localparam int MAX_KEYS        = 256;
  localparam int MAX_QUERY_BYTES = 64;
  localparam int SCAN_SPAN       = 8;

  typedef enum logic [1:0] {
    CMD_KEY_BYTE = 2'd0,
    CMD_KEY_END  = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_NONE     = 2'd3
  } command_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK,
    S_LO_RD,
    S_LO_WAIT,
    S_HI_WAIT,
    S_BYTE_RD,
    S_BYTE_WAIT,
    S_BYTE_CMP,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {T_IDLE, T_BISECT, T_SCAN, T_OUT} top_state_t;

  // compare outcome: query less than or equal, or greater
  typedef struct packed {
    logic valid;
    logic le;
  } cmp_result_t;
endpackage
`default_nettype wire

[design/sklbs_cmp.sv]
// sklbs_cmp: compares the query with one stored key, one byte per pass
// depends on sklbs_pkg; owns the key byte, key end and query byte memories
`timescale 1ns / 1ps
`default_nettype none
module sklbs_cmp #(
  parameter int KEY_STORE_BYTES = sklbs_pkg::KEY_STORE_BYTES,
  parameter int MAX_KEYS        = sklbs_pkg::MAX_KEYS,
  parameter int MAX_QUERY_BYTES = sklbs_pkg::MAX_QUERY_BYTES,
  localparam int KAW = $clog2(KEY_STORE_BYTES),
  localparam int EW  = $clog2(KEY_STORE_BYTES + 1),
  localparam int IW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
  localparam int QAW = (MAX_QUERY_BYTES > 1) ? $clog2(MAX_QUERY_BYTES) : 1,
  localparam int QLW = $clog2(MAX_QUERY_BYTES + 1),
  localparam int NW  = $clog2(MAX_KEYS + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                kb_we,
  input  wire logic [KAW-1:0]      kb_waddr,
  input  wire logic [7:0]          kb_wdata,
  input  wire logic                ke_we,
  input  wire logic [IW-1:0]       ke_waddr,
  input  wire logic [EW-1:0]       ke_wdata,
  input  wire logic                qb_we,
  input  wire logic [QAW-1:0]      qb_waddr,
  input  wire logic [7:0]          qb_wdata,
  input  wire logic [QLW-1:0]      query_length,
  input  wire logic                start,
  input  wire logic [NW-1:0]       key_index,
  output sklbs_pkg::cmp_result_t   result
);
  logic [7:0]     key_mem [KEY_STORE_BYTES];
  logic [EW-1:0]  end_mem [MAX_KEYS];
  logic [7:0]     qry_mem [MAX_QUERY_BYTES];
  logic [7:0]     kb_q;
  logic [7:0]     qb_q;
  logic [EW-1:0]  ke_q;
  logic [IW-1:0]  ke_raddr;
  logic [KAW-1:0] kb_raddr;
  logic [QAW-1:0] qb_raddr;

  sklbs_pkg::state_t state, state_next;
  logic [EW-1:0]  lo, lo_next;
  logic [EW-1:0]  len, len_next;
  logic [QLW-1:0] pos, pos_next;
  logic [IW-1:0]  idx;
  logic           first;
  logic           le, le_next;
  logic [EW:0]    kaddr_sum;

  always_ff @(posedge clk) begin
    if (kb_we) key_mem[kb_waddr] <= kb_wdata;
    if (ke_we) end_mem[ke_waddr] <= ke_wdata;
    if (qb_we) qry_mem[qb_waddr] <= qb_wdata;
    kb_q <= key_mem[kb_raddr];
    qb_q <= qry_mem[qb_raddr];
    ke_q <= end_mem[ke_raddr];
  end

  assign kaddr_sum = {1'b0, lo} + {{(EW+1-QLW){1'b0}}, pos};
  assign kb_raddr  = kaddr_sum[KAW-1:0];
  assign qb_raddr  = pos[QAW-1:0];

  always_comb begin
    ke_raddr = idx;
    if (state == sklbs_pkg::S_PICK && !first) ke_raddr = idx - IW'(1);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx   <= key_index[IW-1:0];
      first <= (key_index == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sklbs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
    lo  <= lo_next;
    len <= len_next;
    pos <= pos_next;
    le  <= le_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sklbs_pkg::S_IDLE:      if (start) state_next = sklbs_pkg::S_PICK;
      sklbs_pkg::S_PICK:      state_next = sklbs_pkg::S_LO_RD;
      sklbs_pkg::S_LO_RD:     state_next = sklbs_pkg::S_LO_WAIT;
      sklbs_pkg::S_LO_WAIT:   state_next = sklbs_pkg::S_HI_WAIT;
      sklbs_pkg::S_HI_WAIT:   state_next = sklbs_pkg::S_BYTE_RD;
      sklbs_pkg::S_BYTE_RD: begin
        if ({{(EW+1-QLW){1'b0}}, pos} >= {1'b0, len} || pos >= query_length)
          state_next = sklbs_pkg::S_DECIDE;
        else
          state_next = sklbs_pkg::S_BYTE_WAIT;
      end
      sklbs_pkg::S_BYTE_WAIT: state_next = sklbs_pkg::S_BYTE_CMP;
      sklbs_pkg::S_BYTE_CMP: begin
        if (qb_q != kb_q) state_next = sklbs_pkg::S_DONE;
        else state_next = sklbs_pkg::S_BYTE_RD;
      end
      sklbs_pkg::S_DECIDE:    state_next = sklbs_pkg::S_DONE;
      sklbs_pkg::S_DONE:      state_next = sklbs_pkg::S_IDLE;
      default:                state_next = sklbs_pkg::S_IDLE;
    endcase
  end

  // clamp offsets, derive start and length of the key, step the byte position and set the outcome
  always_comb begin
    logic [EW-1:0] e;
    e = (ke_q > EW'(KEY_STORE_BYTES)) ? EW'(KEY_STORE_BYTES) : ke_q;
    lo_next  = lo;
    len_next = len;
    pos_next = pos;
    le_next  = le;
    unique case (state)
      sklbs_pkg::S_LO_RD:   lo_next = first ? '0 : e;
      sklbs_pkg::S_LO_WAIT: ;
      sklbs_pkg::S_HI_WAIT: begin
        len_next = (e > lo) ? e - lo : '0;
        pos_next = '0;
      end
      sklbs_pkg::S_BYTE_CMP: begin
        if (qb_q != kb_q) le_next = (qb_q < kb_q);
        else pos_next = pos + QLW'(1);
      end
      sklbs_pkg::S_DECIDE:
        le_next = !({{(EW+1-QLW){1'b0}}, query_length} > {1'b0, len});
      default: ;
    endcase
  end

  always_comb begin
    result.valid = (state == sklbs_pkg::S_DONE);
    result.le    = le;
  end

  // first is stable once a compare is under way
  a_first: assert property (@(posedge clk) disable iff (rst)
    state != sklbs_pkg::S_IDLE && state != sklbs_pkg::S_DONE |=> $stable(first))
    else $error("key index changed during compare");
  a_pos: assert property (@(posedge clk) disable iff (rst)
    state == sklbs_pkg::S_BYTE_WAIT |-> {{(EW+1-QLW){1'b0}}, pos} < {1'b0, len})
    else $error("byte position past key end");
  a_done: assert property (@(posedge clk) disable iff (rst)
    result.valid |=> state == sklbs_pkg::S_IDLE)
    else $error("result held too long");
endmodule
`default_nettype wire

[design/sorted_key_lower_bound_search.sv]
// Lower bound search over a node of variable-length keys held in on-chip
// memory. Loads (key bytes, key end offsets) and query bytes take one word per
// cycle while no search runs; the query word that carries last starts a
// search and the input stalls until its position word is delivered. Each
// probe runs a shared byte comparator: it reads the key's end offsets, then
// compares bytes until one differs or the query or key runs out, all through
// registered reads of the end offset and byte memories. A search makes about
// log2(keys/8) probes and at most 8 scan compares.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_lower_bound_search #(
  parameter int KEY_STORE_BYTES = sklbs_pkg::KEY_STORE_BYTES,
  parameter int MAX_KEYS        = sklbs_pkg::MAX_KEYS,
  parameter int MAX_QUERY_BYTES = sklbs_pkg::MAX_QUERY_BYTES,
  parameter int SCAN_SPAN       = sklbs_pkg::SCAN_SPAN
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [11:0] index,
  input  wire logic [7:0]  data_byte,
  input  wire logic [12:0] end_offset,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [8:0]       position
);
  localparam int KAW = $clog2(KEY_STORE_BYTES);
  localparam int EW  = $clog2(KEY_STORE_BYTES + 1);
  localparam int IW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int QAW = (MAX_QUERY_BYTES > 1) ? $clog2(MAX_QUERY_BYTES) : 1;
  localparam int QLW = $clog2(MAX_QUERY_BYTES + 1);
  localparam int NW  = $clog2(MAX_KEYS + 1);

  sklbs_pkg::top_state_t tstate, tstate_next;
  logic [NW-1:0]       node_keys;
  logic [QLW-1:0]      query_length;
  logic [NW-1:0]       lo, lo_next, hi, hi_next, probe;
  logic                busy;
  logic                cmp_start;
  logic [NW-1:0]       mid;
  sklbs_pkg::cmp_result_t cres;
  logic                in_acc;
  sklbs_pkg::command_t cmd;
  logic [12:0]         qlen_raw;

  assign cmd    = sklbs_pkg::command_t'(command);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = (tstate == sklbs_pkg::T_IDLE);
  assign in_stall  = (tstate != sklbs_pkg::T_IDLE);
  assign qlen_raw  = {1'b0, index} + 13'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_keys    <= '0;
      query_length <= '0;
    end else begin
      if (cfg_valid && cfg_ready)
        node_keys <= ({23'd0, cfg_data} > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(cfg_data);
      if (in_acc && cmd == sklbs_pkg::CMD_QUERY)
        query_length <= ({19'd0, qlen_raw} > MAX_QUERY_BYTES) ? QLW'(MAX_QUERY_BYTES)
                                                          : QLW'(qlen_raw);
    end
  end

  assign mid = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= sklbs_pkg::T_IDLE;
      busy   <= 1'b0;
    end else begin
      tstate <= tstate_next;
      busy   <= cmp_start ? 1'b1 : (cres.valid ? 1'b0 : busy);
    end
    lo <= lo_next;
    hi <= hi_next;
    if (cmp_start) probe <= (tstate == sklbs_pkg::T_BISECT) ? mid : lo;
  end

  always_comb begin
    tstate_next = tstate;
    unique case (tstate)
      sklbs_pkg::T_IDLE:
        if (in_acc && cmd == sklbs_pkg::CMD_QUERY && last) tstate_next = sklbs_pkg::T_BISECT;
      sklbs_pkg::T_BISECT:
        if (!busy && !((hi - lo) > NW'(SCAN_SPAN))) tstate_next = sklbs_pkg::T_SCAN;
      sklbs_pkg::T_SCAN: begin
        if (!busy && lo >= hi) tstate_next = sklbs_pkg::T_OUT;
        if (cres.valid && cres.le) tstate_next = sklbs_pkg::T_OUT;
      end
      sklbs_pkg::T_OUT: if (!out_stall) tstate_next = sklbs_pkg::T_IDLE;
      default: tstate_next = sklbs_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    lo_next   = lo;
    hi_next   = hi;
    cmp_start = 1'b0;
    unique case (tstate)
      sklbs_pkg::T_IDLE: begin
        lo_next = '0;
        hi_next = node_keys;
      end
      sklbs_pkg::T_BISECT: begin
        if (!busy && (hi - lo) > NW'(SCAN_SPAN)) cmp_start = 1'b1;
        if (cres.valid) begin
          if (cres.le) hi_next = probe;
          else lo_next = probe;
        end
      end
      sklbs_pkg::T_SCAN: begin
        if (!busy && lo < hi && !cres.valid) cmp_start = 1'b1;
        if (cres.valid) begin
          if (!cres.le) lo_next = lo + NW'(1);
        end
      end
      sklbs_pkg::T_OUT: ;
      default: ;
    endcase
  end

  assign out_valid = (tstate == sklbs_pkg::T_OUT);
  assign position  = 9'(lo);

  sklbs_cmp #(
    .KEY_STORE_BYTES(KEY_STORE_BYTES),
    .MAX_KEYS(MAX_KEYS),
    .MAX_QUERY_BYTES(MAX_QUERY_BYTES)
  ) u_cmp (
    .clk(clk),
    .rst(rst),
    .kb_we(in_acc && cmd == sklbs_pkg::CMD_KEY_BYTE && {20'd0, index} < KEY_STORE_BYTES),
    .kb_waddr(KAW'(index)),
    .kb_wdata(data_byte),
    .ke_we(in_acc && cmd == sklbs_pkg::CMD_KEY_END && {20'd0, index} < MAX_KEYS),
    .ke_waddr(IW'(index)),
    .ke_wdata(EW'(({19'd0, end_offset} > KEY_STORE_BYTES) ? KEY_STORE_BYTES
                                                           : {19'd0, end_offset})),
    .qb_we(in_acc && cmd == sklbs_pkg::CMD_QUERY && {20'd0, index} < MAX_QUERY_BYTES),
    .qb_waddr(QAW'(index)),
    .qb_wdata(data_byte),
    .query_length(query_length),
    .start(cmp_start),
    .key_index(cmp_start ? ((tstate == sklbs_pkg::T_BISECT) ? mid : lo) : probe),
    .result(cres)
  );

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    tstate != sklbs_pkg::T_IDLE |-> lo <= hi)
    else $error("search window inverted");
  a_nostart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmp_start)
    else $error("compare started while busy");
  a_outpos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lo <= node_keys)
    else $error("position beyond key count");
endmodule
`default_nettype wire
